@@ rtl/sbfd_pkg.sv @@
// Shared types and constants for the S.BUS frame decoder.
package sbfd_pkg;

  localparam int unsigned SBFD_FRAME_BYTES   = 25;
  localparam int unsigned SBFD_CHANNEL_COUNT = 16;
  localparam int unsigned SBFD_CH_BITS       = 11;

  localparam logic [7:0]  SBFD_START_BYTE = 8'h0F;
  localparam logic [11:0] SBFD_VAL_OFFSET = 12'd880;
  localparam logic [11:0] SBFD_VAL_MIN    = 12'd800;
  localparam logic [11:0] SBFD_VAL_MAX    = 12'd2200;

  // bit offset step between packed channels
  localparam logic [7:0] SBFD_CH_STEP = 8'(SBFD_CH_BITS);
  localparam logic [3:0] SBFD_LAST_CH = 4'(SBFD_CHANNEL_COUNT - 1);

  // flag byte bits
  localparam int unsigned SBFD_FLAG_FAILSAFE_BIT = 3;
  localparam int unsigned SBFD_FLAG_LOST_BIT     = 2;

  typedef enum logic [1:0] {
    STATUS_RECEIVED = 2'd0,
    STATUS_LOST     = 2'd1,
    STATUS_FAILSAFE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_WAIT,
    ST_DATA,
    ST_END,
    ST_FLAG_REQ,
    ST_FLAG_CAP,
    ST_BYTE_REQ,
    ST_BYTE_CAP,
    ST_SCALE,
    ST_EMIT
  } state_e;

endpackage

@@ rtl/sbfd_chan_scale.sv @@
// Channel extract from a 3-byte window, scale by 5/8, offset and clamp.
module sbfd_chan_scale
  import sbfd_pkg::*;
(
  input  logic [23:0] win_i,
  input  logic [2:0]  shift_i,
  output logic [11:0] value_o
);

  logic [23:0] shifted;
  logic [10:0] raw;
  logic [13:0] prod;
  logic [10:0] scaled;
  logic [11:0] sum;

  always_comb begin
    shifted = win_i >> shift_i;
    raw     = shifted[10:0];
    // v*5 as v*4 + v
    prod    = {1'b0, raw, 2'b00} + {3'b000, raw};
    scaled  = prod[13:3];
    sum     = {1'b0, scaled} + SBFD_VAL_OFFSET;
    if (sum < SBFD_VAL_MIN) begin
      value_o = SBFD_VAL_MIN;
    end else if (sum > SBFD_VAL_MAX) begin
      value_o = SBFD_VAL_MAX;
    end else begin
      value_o = sum;
    end
  end

endmodule

@@ rtl/sbus_frame_decoder_unit.sv @@
// S.BUS frame decoder top level: byte collector, frame store and channel sequencer.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid_i/in_ready_o | rx_byte_i
//  out     | output    | out_valid_o/out_ready_i| channel_index_o, channel_value_o,
//          |           |                      | frame_status_o, flag_byte_o, last_channel_o
//
// Flow: one byte request per cycle while a frame is collected. After the final byte
//   the block reads the flag byte, then per channel makes three frame store reads
//   over its single registered read port, a scale step and at least one emit step;
//   the store read port sets the pace at which a frame's channels are produced.
// Reset: asynchronous, active low; returns to waiting for the start byte. The frame
//   store is not cleared, every entry read is written earlier in the same frame.
// Stalls: in_ready_o is low while results are produced; a stalled result holds in the
//   output registers until out_ready_i takes it.
module sbus_frame_decoder_unit
  import sbfd_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = SBFD_FRAME_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  channel_index_o,
  output logic [11:0] channel_value_o,
  output logic [1:0]  frame_status_o,
  output logic [7:0]  flag_byte_o,
  output logic        last_channel_o
);

  localparam int unsigned AW = $clog2(FRAME_BYTES);
  localparam logic [AW-1:0] FlagAddr   = AW'(FRAME_BYTES - 2);
  localparam logic [AW-1:0] EndPos     = AW'(FRAME_BYTES - 1);
  localparam logic [AW-1:0] FirstData  = AW'(1);

  state_e        state_q, state_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [3:0]    ch_q, ch_d;
  logic [7:0]    bit_q, bit_d;       // bit offset of current channel in data area
  logic [1:0]    byte_cnt_q, byte_cnt_d;
  logic [23:0]   win_q, win_d;
  logic [7:0]    flag_q, flag_d;
  logic [1:0]    status_q, status_d;
  logic [11:0]   value_q, value_d;

  logic [7:0]    mem_q [FRAME_BYTES];
  logic [7:0]    rdata_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          mem_we;
  logic          in_acc;
  logic [11:0]   scaled;

  assign in_acc = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_WAIT: begin
        if (in_acc && rx_byte_i == SBFD_START_BYTE) state_d = ST_DATA;
      end
      ST_DATA: begin
        // last data byte is the flag byte; the end byte follows
        if (in_acc && (pos_q + FirstData) >= EndPos) state_d = ST_END;
      end
      ST_END: begin
        if (in_acc) state_d = ST_FLAG_REQ;
      end
      ST_FLAG_REQ: state_d = ST_FLAG_CAP;
      ST_FLAG_CAP: state_d = ST_BYTE_REQ;
      ST_BYTE_REQ: state_d = ST_BYTE_CAP;
      ST_BYTE_CAP: begin
        state_d = (byte_cnt_q == 2'd2) ? ST_SCALE : ST_BYTE_REQ;
      end
      ST_SCALE: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_ready_i) state_d = (ch_q == SBFD_LAST_CH) ? ST_WAIT : ST_BYTE_REQ;
      end
      default: state_d = ST_WAIT;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    mem_we      = 1'b0;
    wr_addr     = pos_q;
    rd_addr     = FlagAddr;
    case (state_q)
      ST_WAIT: begin
        in_ready_o = 1'b1;
        wr_addr    = '0;
        mem_we     = in_acc && rx_byte_i == SBFD_START_BYTE;
      end
      ST_DATA, ST_END: begin
        in_ready_o = 1'b1;
        mem_we     = in_acc;
      end
      ST_BYTE_REQ: rd_addr = FirstData + AW'(bit_q[7:3]) + AW'(byte_cnt_q);
      ST_EMIT:     out_valid_o = 1'b1;
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    pos_d      = pos_q;
    ch_d       = ch_q;
    bit_d      = bit_q;
    byte_cnt_d = byte_cnt_q;
    win_d      = win_q;
    flag_d     = flag_q;
    status_d   = status_q;
    value_d    = value_q;
    case (state_q)
      ST_WAIT: begin
        if (in_acc) pos_d = (rx_byte_i == SBFD_START_BYTE) ? FirstData : '0;
      end
      ST_DATA: begin
        if (in_acc) pos_d = pos_q + FirstData;
      end
      ST_END: begin
        if (in_acc) pos_d = '0;
      end
      ST_FLAG_CAP: begin
        flag_d = rdata_q;
        if (rdata_q[SBFD_FLAG_FAILSAFE_BIT]) begin
          status_d = STATUS_FAILSAFE;
        end else if (rdata_q[SBFD_FLAG_LOST_BIT]) begin
          status_d = STATUS_LOST;
        end else begin
          status_d = STATUS_RECEIVED;
        end
        ch_d       = '0;
        bit_d      = '0;
        byte_cnt_d = '0;
      end
      ST_BYTE_CAP: begin
        case (byte_cnt_q)
          2'd0:    win_d[7:0]   = rdata_q;
          2'd1:    win_d[15:8]  = rdata_q;
          default: win_d[23:16] = rdata_q;
        endcase
        byte_cnt_d = byte_cnt_q + 2'd1;
      end
      ST_SCALE: value_d = scaled;
      ST_EMIT: begin
        if (out_ready_i && ch_q != SBFD_LAST_CH) begin
          ch_d       = ch_q + 4'd1;
          bit_d      = bit_q + SBFD_CH_STEP;
          byte_cnt_d = '0;
        end
      end
      default: ;
    endcase
  end

  sbfd_chan_scale u_scale (
    .win_i   (win_q),
    .shift_i (bit_q[2:0]),
    .value_o (scaled)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_WAIT;
      pos_q      <= '0;
      ch_q       <= '0;
      bit_q      <= '0;
      byte_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      pos_q      <= pos_d;
      ch_q       <= ch_d;
      bit_q      <= bit_d;
      byte_cnt_q <= byte_cnt_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    win_q    <= win_d;
    flag_q   <= flag_d;
    status_q <= status_d;
    value_q  <= value_d;
  end

  // frame store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wr_addr] <= rx_byte_i;
    rdata_q <= mem_q[rd_addr];
  end

  assign channel_index_o = ch_q;
  assign channel_value_o = value_q;
  assign frame_status_o  = status_q;
  assign flag_byte_o     = flag_q;
  assign last_channel_o  = (ch_q == SBFD_LAST_CH);

  // no byte requests taken while results are pending
  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while result pending");

  // last channel taken returns the sequencer to start-byte search
  a_last_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_channel_o |=> state_q == ST_WAIT)
    else $error("sequencer did not return after last channel");

  // channel reads stay inside the data area, up to and including the flag byte
  a_rd_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BYTE_REQ |-> rd_addr >= FirstData && rd_addr <= FlagAddr)
    else $error("channel read outside data area");

  // window fill never runs past three bytes
  a_byte_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BYTE_CAP |-> byte_cnt_q != 2'd3)
    else $error("window byte count overflow");

  // first result of a frame is channel zero
  a_first_ch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FLAG_CAP |=> ch_q == 4'd0 && bit_q == 8'd0)
    else $error("channel counter not cleared at frame start");

endmodule
